// ===== rtl/pbd_pkg.sv =====
package pbd_pkg;

  localparam int COORD_W = 16;
  localparam int GAP_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * GAP_W;
  localparam int SUM_W   = 40;
  localparam int ALU_W   = SUM_W + 1;
  localparam int DIST_W  = 19;
  localparam int IN_W    = 3 * COORD_W;
  localparam int OUT_W   = ((DIST_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [SUM_W-1:0]  ROOT_BIT0 = SUM_W'(1) << (SUM_W - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BELOW,
    ST_ABOVE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SEL_BELOW,
    SEL_ABOVE,
    SEL_ACCUM,
    SEL_ROOT
  } alu_sel_t;

  typedef struct packed {
    logic     load;
    alu_sel_t sel;
    logic     gap_en;
    logic     square_en;
    logic     accum_en;
    logic     root_init;
    logic     root_step;
    logic     emit;
    logic     pick_root;
  } ctrl_t;

  typedef struct packed {
    logic last;
    logic gap_pos;
    logic bit_done;
    logic out_full;
  } status_t;

endpackage

// ===== rtl/pbd_alu.sv =====
module pbd_alu
  import pbd_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] res
);

  assign res = sub ? (a - b) : (a + b);

endmodule

// ===== rtl/pbd_dp.sv =====
module pbd_dp
  import pbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctl,
  output status_t           sts,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata
);

  logic signed [COORD_W-1:0] query_coord;
  logic signed [COORD_W-1:0] box_low;
  logic signed [COORD_W-1:0] box_high;
  logic                      last_element;
  logic [GAP_W-1:0]          gap;
  logic [SQ_W-1:0]           square;
  logic [SUM_W-1:0]          square_sum;
  logic [SUM_W-1:0]          square_sum_next;
  logic [GAP_W-1:0]          largest_gap;
  logic [SUM_W-1:0]          rem;
  logic [SUM_W-1:0]          root;
  logic [SUM_W-1:0]          root_bit;
  logic [DIST_W-1:0]         distance;
  logic [DIST_W-1:0]         result;
  logic                      out_valid;

  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_res;
  logic             alu_sub;
  logic             alu_pos;

  // Operand select for the shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (ctl.sel)
      SEL_BELOW: begin
        alu_a = {{(ALU_W-COORD_W){box_low[COORD_W-1]}}, box_low};
        alu_b = {{(ALU_W-COORD_W){query_coord[COORD_W-1]}}, query_coord};
      end
      SEL_ABOVE: begin
        alu_a = {{(ALU_W-COORD_W){query_coord[COORD_W-1]}}, query_coord};
        alu_b = {{(ALU_W-COORD_W){box_high[COORD_W-1]}}, box_high};
      end
      SEL_ACCUM: begin
        alu_a   = {1'b0, square_sum};
        alu_b   = {{(ALU_W-SQ_W){1'b0}}, square};
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = {1'b0, rem};
        alu_b = {1'b0, root | root_bit};
      end
    endcase
  end

  pbd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign alu_pos         = !alu_res[ALU_W-1] && (alu_res != '0);
  // carry out of the add saturates the sum
  assign square_sum_next = alu_res[ALU_W-1] ? SUM_MAX : alu_res[SUM_W-1:0];

  assign result = ctl.pick_root
                ? ((root[SUM_W-1:DIST_W] != '0) ? DIST_MAX : root[DIST_W-1:0])
                : {{(DIST_W-GAP_W){1'b0}}, largest_gap};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      query_coord  <= s_tdata[COORD_W-1:0];
      box_low      <= s_tdata[2*COORD_W-1:COORD_W];
      box_high     <= s_tdata[3*COORD_W-1:2*COORD_W];
      last_element <= s_tlast;
    end
    if (ctl.gap_en) begin
      gap <= alu_pos ? alu_res[GAP_W-1:0] : '0;
    end
    if (ctl.square_en) begin
      square <= SQ_W'(gap) * SQ_W'(gap);
    end
    if (ctl.root_init) begin
      rem      <= square_sum_next;
      root     <= '0;
      root_bit <= ROOT_BIT0;
    end else if (ctl.root_step) begin
      if (!alu_res[ALU_W-1]) begin
        rem  <= alu_res[SUM_W-1:0];
        root <= (root >> 1) | root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (ctl.emit) begin
      distance <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum  <= '0;
      largest_gap <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.emit) begin
        square_sum  <= '0;
        largest_gap <= '0;
      end else if (ctl.accum_en) begin
        square_sum <= square_sum_next;
        if (gap > largest_gap) begin
          largest_gap <= gap;
        end
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid     = out_valid;
  assign m_tdata      = {{(OUT_W-DIST_W){1'b0}}, distance};
  assign sts.last     = last_element;
  assign sts.gap_pos  = alu_pos;
  assign sts.bit_done = root_bit[0];
  assign sts.out_full = out_valid;

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> (square_sum == '0) && (largest_gap == '0))
    else $error("accumulators not cleared after result");

  a_root_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    ctl.root_step |-> $onehot(root_bit))
    else $error("root bit lost its single set bit");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> m_tvalid)
    else $error("result not presented after emit");

endmodule

// ===== rtl/pbd_ctrl.sv =====
module pbd_ctrl
  import pbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data,
  input  status_t sts,
  output ctrl_t   ctl
);

  state_t state;
  state_t state_next;
  logic   metric_mode;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      metric_mode <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        metric_mode <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_BELOW;
      ST_BELOW:  state_next = sts.gap_pos ? ST_SQUARE : ST_ABOVE;
      ST_ABOVE:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (!sts.last) begin
          state_next = ST_IDLE;
        end else if (metric_mode) begin
          state_next = ST_ROOT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_ROOT:   if (sts.bit_done) state_next = ST_EMIT;
      ST_EMIT:   if (!sts.out_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.sel       = SEL_ROOT;
    ctl.pick_root = metric_mode;
    ctl.load      = accept;
    unique case (state)
      ST_BELOW: begin
        ctl.sel    = SEL_BELOW;
        ctl.gap_en = 1'b1;
      end
      ST_ABOVE: begin
        ctl.sel    = SEL_ABOVE;
        ctl.gap_en = 1'b1;
      end
      ST_SQUARE: ctl.square_en = 1'b1;
      ST_ACCUM: begin
        ctl.sel       = SEL_ACCUM;
        ctl.accum_en  = 1'b1;
        ctl.root_init = sts.last && metric_mode;
      end
      ST_ROOT:  ctl.root_step = 1'b1;
      // hold the result until the output register is free
      ST_EMIT:  ctl.emit = !sts.out_full;
      default:  ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_BELOW)
    else $error("accepted beat did not start the gap test");

  a_root_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |=> state == ST_ROOT || state == ST_EMIT)
    else $error("root iteration left early");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready)
    else $error("input taken while busy");

endmodule

// ===== rtl/point_box_distance_unit_core.sv =====
// Distance from a query point to an axis-aligned box (or to a second point,
// with box_low equal to box_high), one dimension per input beat, signed Q8.8
// coordinates. metric_mode 0 reports the largest gap outside the bounds
// (Chebyshev); metric_mode 1, the reset value, reports the truncated square
// root of the sum of squared gaps (Euclidean), saturated to 19 bits. One
// distance beat comes out for each beat with tlast set; the mode is taken at
// that beat. Every beat passes through one shared 41-bit add/subtract unit:
// each dimension is tested below the low bound, then above the high bound
// unless it was below, then squared and accumulated; the closing beat then
// issues the result, after a bit-by-bit square root in Euclidean mode. The
// input is not ready while a beat is being worked on; a result waiting on
// the output does not block accumulation of the next vector.
module point_box_distance_unit_core
  import pbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // query_coord, box_low, box_high
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // distance, zero pad
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  ctrl_t   ctl;
  status_t sts;

  pbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .ctl       (ctl)
  );

  pbd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== verif/point_box_distance_unit_core_test.sv =====
`timescale 1ns / 100ps

module point_box_distance_unit_core_test;
  import pbd_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam int     SETTLE_CYCLES = 40;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     ITEM_TARGET   = 1150;
  localparam coord_t COORD_MIN     = coord_t'(16'h8000);
  localparam coord_t COORD_MAX     = coord_t'(16'h7fff);

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;   // query_coord, box_low, box_high
  logic              s_tlast   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;          // distance, zero pad
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data  = 1'b0;

  // predictor state
  logic              metric_euclid = 1'b1;
  logic [SUM_W-1:0]  sq_gap_sum    = '0;
  logic [COORD_W:0]  max_gap       = '0;
  logic [DIST_W-1:0] expected_dist[$];

  logic src_idling  = 1'b1;
  logic sink_idling = 1'b1;
  logic hold_req    = 1'b0;
  int   hold_left   = 0;

  int dims_sent     = 0;
  int vectors_sent  = 0;
  int dists_checked = 0;
  int mismatches    = 0;
  int mode_writes   = 0;

  point_box_distance_unit_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gap of the query outside [lo, hi]; the below-low test wins on an inverted box
  function automatic logic [COORD_W:0] box_gap(coord_t q, coord_t lo, coord_t hi);
    if (q < lo)
      return (COORD_W + 1)'(int'(lo) - int'(q));
    else if (q > hi)
      return (COORD_W + 1)'(int'(q) - int'(hi));
    return '0;
  endfunction

  function automatic logic [DIST_W-1:0] root_dist(logic [SUM_W-1:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= 64'(v))
        r = t;
    end
    if (r > 64'(DIST_MAX))
      return DIST_MAX;
    return DIST_W'(r);
  endfunction

  // fold one accepted dimension into the running sums
  function automatic void accumulate_dim(coord_t q, coord_t lo, coord_t hi, logic last);
    logic [COORD_W:0] g;
    logic [63:0]      total;
    g = box_gap(q, lo, hi);
    if (g > max_gap)
      max_gap = g;
    total = 64'(sq_gap_sum) + 64'(g) * 64'(g);
    sq_gap_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
    if (last) begin
      expected_dist = {expected_dist,
                       (metric_euclid ? root_dist(sq_gap_sum) : DIST_W'(max_gap))};
      sq_gap_sum = '0;
      max_gap    = '0;
      vectors_sent++;
    end
    dims_sent++;
  endfunction

  task automatic send_dim(coord_t q, coord_t lo, coord_t hi, logic last);
    while (src_idling && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hi, lo, q};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    accumulate_dim(q, lo, hi, last);
  endtask

  task automatic drop_valid;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return coord_t'($urandom_range(512)) - coord_t'(256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // shape 0: free box (often inverted), 1: point, 2: ordered box
  task automatic send_vector(int len, int shape);
    coord_t q;
    coord_t lo;
    coord_t hi;
    coord_t t;
    for (int i = 0; i < len; i++) begin
      q  = rand_coord();
      lo = rand_coord();
      hi = (shape == 1) ? lo : rand_coord();
      if (shape == 2 && lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      send_dim(q, lo, hi, i == len - 1);
    end
  endtask

  task automatic wait_drain;
    while (expected_dist.size() != 0)
      @(posedge clk);
  endtask

  // write the mode only once the block has gone quiet
  task automatic set_metric(logic euclid);
    drop_valid();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= euclid;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    metric_euclid = euclid;
    mode_writes++;
    cfg_valid <= 1'b0;
  endtask

  // checker and sink
  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_dist.size() == 0) begin
        $error("distance beat with no vector pending: got %0d", m_tdata[DIST_W-1:0]);
        mismatches++;
      end else begin
        want = expected_dist.pop_front();
        if (m_tdata[DIST_W-1:0] !== want) begin
          $error("distance: expected %0d, actual %0d", want, m_tdata[DIST_W-1:0]);
          mismatches++;
        end
        dists_checked++;
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rst)
      m_tready <= 1'b0;
    else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (sink_idling)
      m_tready <= ($urandom_range(99) >= 33);
    else
      m_tready <= 1'b1;
  end

  task automatic test_euclid_directed;
    // runs on the reset mode
    send_dim(16'sd256, 16'sd512, 16'sd512, 1'b1);      // point, query below
    send_dim(16'sd1000, -16'sd50, -16'sd50, 1'b1);     // point, query above
    send_dim(16'sd10, -16'sd100, 16'sd100, 1'b1);      // inside the box
    send_dim(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);   // widest gap
    send_dim(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    send_dim(16'sd0, 16'sd100, -16'sd100, 1'b1);       // inverted box, below low wins
    send_dim(16'sd200, 16'sd100, -16'sd100, 1'b1);     // inverted box, above high
    send_dim(16'sd768, 16'sd0, 16'sd0, 1'b0);          // 3-4-5 triangle
    send_dim(-16'sd1024, 16'sd0, 16'sd0, 1'b1);
    send_dim(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_dim(COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);   // all gaps zero
  endtask

  task automatic test_chebyshev_directed;
    set_metric(1'b0);
    send_dim(16'sd300, 16'sd0, 16'sd100, 1'b0);
    send_dim(-16'sd500, 16'sd0, 16'sd0, 1'b0);
    send_dim(16'sd5, 16'sd0, 16'sd10, 1'b1);
    send_dim(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
    send_dim(COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
    send_dim(16'sd0, 16'sd100, -16'sd100, 1'b1);
    send_dim(16'sd200, 16'sd100, -16'sd100, 1'b1);
    send_dim(16'sd0, 16'sd0, 16'sd0, 1'b1);
  endtask

  // mode is taken at the closing beat, so switching mid-vector picks the other sum
  task automatic test_mode_switch_mid_vector;
    send_dim(16'sd1000, 16'sd0, 16'sd0, 1'b0);
    send_dim(-16'sd700, 16'sd0, 16'sd0, 1'b0);
    set_metric(1'b1);
    send_dim(16'sd300, 16'sd0, 16'sd0, 1'b1);
    send_dim(16'sd900, 16'sd0, 16'sd100, 1'b0);
    send_dim(COORD_MIN, 16'sd0, 16'sd0, 1'b0);
    set_metric(1'b0);
    send_dim(16'sd40, 16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_long_vectors;
    set_metric(1'b1);
    // widest gap 300 times: the sum saturates and so does the root
    for (int i = 0; i < 300; i++)
      send_dim(COORD_MIN, COORD_MAX, COORD_MAX, i == 299);
    // 80 widest gaps: root above the field without a saturated sum
    for (int i = 0; i < 80; i++)
      send_dim(COORD_MAX, COORD_MIN, COORD_MIN, i == 79);
    // past the nominal dimension count with ordinary data
    send_vector(70, 0);
    set_metric(1'b0);
    send_vector(70, 0);
  endtask

  task automatic test_output_stall;
    src_idling = 1'b0;
    hold_req   = 1'b1;
    for (int v = 0; v < 10; v++)
      send_vector($urandom_range(1, 3), $urandom_range(2));
    src_idling = 1'b1;
    // hold off the sender until every distance is out
    drop_valid();
    wait_drain();
  endtask

  task automatic test_random_vectors;
    int phase;
    int len;
    phase = 0;
    while (dims_sent < ITEM_TARGET) begin
      if (phase % 3 == 0)
        set_metric(phase % 6 == 0);
      // one long stretch with no idling on either side
      src_idling  = !(phase >= 6 && phase < 10);
      sink_idling = src_idling;
      for (int v = 0; v < 10 && dims_sent < ITEM_TARGET; v++) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
        send_vector(len, $urandom_range(2));
      end
      phase++;
    end
    // send one last single-dimension vector
    send_dim(rand_coord(), rand_coord(), rand_coord(), 1'b1);
    src_idling  = 1'b1;
    sink_idling = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_euclid_directed();
    test_chebyshev_directed();
    test_mode_switch_mid_vector();
    test_long_vectors();
    test_output_stall();
    test_random_vectors();
    drop_valid();
    for (int k = 0; k < 20000 && expected_dist.size() != 0; k++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_dist.size() != 0) begin
      $error("%0d distances never arrived", expected_dist.size());
      mismatches++;
    end
    $display("Sent %0d dimensions in %0d vectors across %0d mode writes.",
             dims_sent, vectors_sent, mode_writes);
    $display("Checked %0d distances; %0d mismatches.", dists_checked, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
